/* hw/rtl/mcwsm_pkg.sv */
// ----------------------------------------------------------------------------
// mcwsm_pkg
// Shared types and constants of the multi-channel wheel speed meter.
// ----------------------------------------------------------------------------
package mcwsm_pkg;

  // default sizes
  localparam int unsigned CHANNELS_DEF      = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF    = 32;

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CH_FIELD_W = 3;
  localparam int unsigned TS_FIELD_W = 32;
  localparam int unsigned WHOLE_W   = 8;
  localparam int unsigned HUND_W    = 7;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 27;
  localparam int unsigned STALE_W   = 8;
  localparam int unsigned TPS_W     = 27;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S = 2'd1;

  localparam logic [STALE_W-1:0] STALE_LIMIT_RST = 8'd2;
  localparam logic [TPS_W-1:0]   TPS_RST         = 27'd1000000;
  localparam logic [STALE_W-1:0] STALE_MAX       = 8'd255;

  // fixed-point speed, two decimal digits, saturated at 255.99
  localparam int unsigned          QW    = 15;
  localparam logic [QW-1:0]        Q_MAX = 15'd25599;
  localparam int unsigned          CENTS = 100;

  // q / 100 by reciprocal, exact for q below 43690
  localparam int unsigned PROD_W    = 28;
  localparam int unsigned DEC_RECIP = 5243;
  localparam int unsigned DEC_SHIFT = 19;

  typedef enum logic [OP_W-1:0] {
    OP_PULSE  = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPORT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_NEW,
    ST_SPAN,
    ST_DIV,
    ST_EMIT
  } state_e;

  // control from sequencer to history store
  typedef struct packed {
    logic pulse;
    logic tick;
    logic rd_en;
    logic rd_newest;
  } hist_ctrl_t;

  // one channel result ahead of decimal split
  typedef struct packed {
    logic [CH_FIELD_W-1:0] ch;
    logic [QW-1:0]         q;
    logic                  last;
  } res_t;

endpackage

/* hw/rtl/mcwsm_history.sv */
// ----------------------------------------------------------------------------
// mcwsm_history
// Per-channel timestamp rings, ring pointers, fill flags and staleness counts.
// ----------------------------------------------------------------------------
module mcwsm_history #(
  parameter int unsigned CHANNELS      = mcwsm_pkg::CHANNELS_DEF,
  parameter int unsigned HISTORY_DEPTH = mcwsm_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH    = mcwsm_pkg::TIME_WIDTH_DEF,
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcwsm_pkg::hist_ctrl_t         ctrl_i,
  input  logic [CW-1:0]                 wr_ch_i,
  input  logic [TIME_WIDTH-1:0]         wr_ts_i,
  input  logic [CW-1:0]                 rd_ch_i,
  output logic [TIME_WIDTH-1:0]         rd_data_o,
  output logic [mcwsm_pkg::STALE_W-1:0] rd_stale_o
);

  localparam int unsigned PW        = $clog2(HISTORY_DEPTH);
  localparam int unsigned AW        = CW + PW;
  localparam int unsigned MEM_DEPTH = CHANNELS * (2 ** PW);

  logic [PW-1:0]                 ptr_q     [CHANNELS];
  logic                          wrapped_q [CHANNELS];
  logic [mcwsm_pkg::STALE_W-1:0] stale_q   [CHANNELS];

  logic [TIME_WIDTH-1:0] mem_q [MEM_DEPTH];
  logic [TIME_WIDTH-1:0] rd_raw_q;
  logic                  rd_valid_q;

  logic [PW-1:0] wr_ptr, wr_ptr_nxt, rd_ptr, rd_idx;
  logic          rd_wrap, rd_valid;

  // pointer bookkeeping
  always_comb begin
    wr_ptr     = ptr_q[wr_ch_i];
    wr_ptr_nxt = (wr_ptr == PW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    rd_ptr     = ptr_q[rd_ch_i];
    rd_wrap    = wrapped_q[rd_ch_i];
  end

  // oldest entry sits at the pointer, newest just before it
  always_comb begin
    if (ctrl_i.rd_newest) begin
      rd_idx   = (rd_ptr == '0) ? PW'(HISTORY_DEPTH - 1) : rd_ptr - 1'b1;
      rd_valid = rd_wrap || (rd_ptr != '0);
    end else begin
      rd_idx   = rd_ptr;
      rd_valid = rd_wrap;
    end
  end

  assign rd_stale_o = stale_q[rd_ch_i];

  // per-channel control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c]     <= '0;
        wrapped_q[c] <= 1'b0;
        stale_q[c]   <= '0;
      end
    end else begin
      if (ctrl_i.tick) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (stale_q[c] != mcwsm_pkg::STALE_MAX) begin
            stale_q[c] <= stale_q[c] + 1'b1;
          end
        end
      end
      if (ctrl_i.pulse) begin
        ptr_q[wr_ch_i]   <= wr_ptr_nxt;
        stale_q[wr_ch_i] <= '0;
        if (wr_ptr == PW'(HISTORY_DEPTH - 1)) begin
          wrapped_q[wr_ch_i] <= 1'b1;
        end
      end
    end
  end

  // timestamp memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pulse) begin
      mem_q[AW'({wr_ch_i, wr_ptr})] <= wr_ts_i;
    end
    if (ctrl_i.rd_en) begin
      rd_raw_q <= mem_q[AW'({rd_ch_i, rd_idx})];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (ctrl_i.rd_en) begin
      rd_valid_q <= rd_valid;
    end
  end

  assign rd_data_o = rd_valid_q ? rd_raw_q : '0;

endmodule

/* hw/rtl/mcwsm_serial_div.sv */
// ----------------------------------------------------------------------------
// mcwsm_serial_div
// Bit-serial restoring divider, one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
module mcwsm_serial_div #(
  parameter int unsigned NW = 38,
  parameter int unsigned TW = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NW-1:0]            dividend_i,
  input  logic [TW-1:0]            divisor_i,
  output logic                     done_o,
  output logic [mcwsm_pkg::QW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(NW);
  localparam int unsigned QW   = mcwsm_pkg::QW;

  logic [NW-1:0]   num_q;
  logic [TW-1:0]   dvs_q;
  logic [TW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   q_q;
  logic            ovf_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;

  logic [TW:0] rem_sh;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? TW'(rem_sh - {1'b0, dvs_q}) : rem_sh[TW-1:0];
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= rem_d;
      q_q   <= {q_q[QW-2:0], ge};
      ovf_q <= ovf_q | q_q[QW-1];
    end
  end

  assign done_o = done_q;
  assign quot_o = (ovf_q || (q_q > mcwsm_pkg::Q_MAX)) ? mcwsm_pkg::Q_MAX : q_q;

endmodule

/* hw/rtl/mcwsm_out_stage.sv */
// ----------------------------------------------------------------------------
// mcwsm_out_stage
// Splits a speed into whole and hundredths and holds the result item.
// ----------------------------------------------------------------------------
module mcwsm_out_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  mcwsm_pkg::res_t                  res_i,
  output logic                             load_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mcwsm_pkg::CH_FIELD_W-1:0] report_channel_o,
  output logic [mcwsm_pkg::WHOLE_W-1:0]    speed_whole_o,
  output logic [mcwsm_pkg::HUND_W-1:0]     speed_hundredths_o,
  output logic                             last_o
);

  localparam int unsigned QW = mcwsm_pkg::QW;

  logic                            s1_v_q;
  mcwsm_pkg::res_t                 s1_res_q;
  logic [mcwsm_pkg::WHOLE_W-1:0]   s1_whole_q;
  logic                            out_v_q;
  logic [mcwsm_pkg::PROD_W-1:0]    prod;
  logic [QW-1:0]                   hund_full;
  logic                            move;

  // whole part by reciprocal multiply
  assign prod = mcwsm_pkg::PROD_W'(res_i.q) * mcwsm_pkg::PROD_W'(mcwsm_pkg::DEC_RECIP);

  // remainder after the registered whole part
  assign hund_full = s1_res_q.q - QW'(s1_whole_q) * QW'(mcwsm_pkg::CENTS);

  assign move         = s1_v_q && (!out_v_q || out_ready_i);
  assign load_ready_o = !s1_v_q;

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (load_i) begin
        s1_v_q <= 1'b1;
      end else if (move) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_res_q   <= res_i;
      s1_whole_q <= prod[mcwsm_pkg::DEC_SHIFT +: mcwsm_pkg::WHOLE_W];
    end
    if (move) begin
      report_channel_o   <= s1_res_q.ch;
      speed_whole_o      <= s1_whole_q;
      speed_hundredths_o <= hund_full[mcwsm_pkg::HUND_W-1:0];
      last_o             <= s1_res_q.last;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

/* hw/rtl/multi_channel_wheel_speed_meter.sv */
// ----------------------------------------------------------------------------
// multi_channel_wheel_speed_meter
// Per-channel pulse-period tachometer with a bit-serial speed divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): op 0 stores a pulse timestamp in the ring of
//   the given channel and clears its staleness count, op 1 is a slow tick that
//   ages every channel, op 2 requests a report. Pulse and tick items can follow
//   back to back.
//   A report gives CHANNELS result items in channel order, last set on the
//   final one. For each channel the bit-serial divider works through an NW-bit
//   dividend, NW = 27 plus the bit count of (HISTORY_DEPTH-1)*100 (38 at the
//   defaults), producing one quotient bit per cycle; no new item is accepted
//   while a report runs.
//   Configuration (valid/ready, always ready): index 0 stale limit, index 1
//   timestamp counts per second; write only while idle.
//   Reset clears pointers, fill flags and staleness counts; ring entries that
//   were never written read as zero, so there is no clearing pass.
//   Results wait in a two-deep output pipe; a stalled receiver holds the
//   report sequencer, while the last result of a report may still drain
//   after new items are already being taken.
// ----------------------------------------------------------------------------
module multi_channel_wheel_speed_meter #(
  parameter int unsigned CHANNELS      = mcwsm_pkg::CHANNELS_DEF,
  parameter int unsigned HISTORY_DEPTH = mcwsm_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH    = mcwsm_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mcwsm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcwsm_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mcwsm_pkg::OP_W-1:0]       op_i,
  input  logic [mcwsm_pkg::CH_FIELD_W-1:0] channel_i,
  input  logic [mcwsm_pkg::TS_FIELD_W-1:0] timestamp_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mcwsm_pkg::CH_FIELD_W-1:0] report_channel_o,
  output logic [mcwsm_pkg::WHOLE_W-1:0]    speed_whole_o,
  output logic [mcwsm_pkg::HUND_W-1:0]     speed_hundredths_o,
  output logic                             last_o
);

  localparam int unsigned CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned KVAL = (HISTORY_DEPTH - 1) * mcwsm_pkg::CENTS;
  localparam int unsigned KW   = $clog2(KVAL + 1);
  localparam int unsigned NW   = mcwsm_pkg::TPS_W + KW;

  mcwsm_pkg::state_e state_q, state_d;

  logic [mcwsm_pkg::STALE_W-1:0] stale_limit_q;
  logic [mcwsm_pkg::TPS_W-1:0]   tps_q;
  logic [NW-1:0]                 num_q;

  logic [CW-1:0]         ch_q;
  logic                  stale_flag_q;
  logic                  zero_q;
  logic [TIME_WIDTH-1:0] old_q;

  logic                          accept;
  logic                          ch_ok;
  mcwsm_pkg::hist_ctrl_t         hist_ctrl;
  logic [TIME_WIDTH-1:0]         hist_rd_data;
  logic [mcwsm_pkg::STALE_W-1:0] hist_stale;
  logic [TIME_WIDTH-1:0]         span;
  logic                          div_start, div_done;
  logic [mcwsm_pkg::QW-1:0]      div_quot;
  logic                          load, load_ready;
  mcwsm_pkg::res_t               res;
  logic                          last_ch;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == mcwsm_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign ch_ok       = int'(channel_i) < CHANNELS;
  assign last_ch     = (ch_q == CW'(CHANNELS - 1));
  assign span        = hist_rd_data - old_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_limit_q <= mcwsm_pkg::STALE_LIMIT_RST;
      tps_q         <= mcwsm_pkg::TPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mcwsm_pkg::REG_STALE_LIMIT: stale_limit_q <= cfg_data_i[mcwsm_pkg::STALE_W-1:0];
        mcwsm_pkg::REG_TICKS_PER_S: tps_q         <= cfg_data_i[mcwsm_pkg::TPS_W-1:0];
        default: ;
      endcase
    end
  end

  // dividend (depth-1)*rate*100, follows the rate register
  always_ff @(posedge clk_i) begin
    num_q <= NW'(tps_q) * NW'(KVAL);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcwsm_pkg::ST_IDLE: begin
        if (accept && (mcwsm_pkg::op_e'(op_i) == mcwsm_pkg::OP_REPORT)) begin
          state_d = mcwsm_pkg::ST_RD_OLD;
        end
      end
      mcwsm_pkg::ST_RD_OLD: state_d = mcwsm_pkg::ST_RD_NEW;
      mcwsm_pkg::ST_RD_NEW: state_d = mcwsm_pkg::ST_SPAN;
      mcwsm_pkg::ST_SPAN:   state_d = mcwsm_pkg::ST_DIV;
      mcwsm_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = mcwsm_pkg::ST_EMIT;
        end
      end
      mcwsm_pkg::ST_EMIT: begin
        if (load_ready) begin
          state_d = last_ch ? mcwsm_pkg::ST_IDLE : mcwsm_pkg::ST_RD_OLD;
        end
      end
      default: state_d = mcwsm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    hist_ctrl = '0;
    div_start = 1'b0;
    load      = 1'b0;
    case (state_q)
      mcwsm_pkg::ST_IDLE: begin
        if (accept) begin
          case (mcwsm_pkg::op_e'(op_i))
            mcwsm_pkg::OP_PULSE: hist_ctrl.pulse = ch_ok;
            mcwsm_pkg::OP_TICK:  hist_ctrl.tick  = 1'b1;
            default: ;
          endcase
        end
      end
      mcwsm_pkg::ST_RD_OLD: hist_ctrl.rd_en = 1'b1;
      mcwsm_pkg::ST_RD_NEW: begin
        hist_ctrl.rd_en     = 1'b1;
        hist_ctrl.rd_newest = 1'b1;
      end
      mcwsm_pkg::ST_SPAN: div_start = 1'b1;
      mcwsm_pkg::ST_EMIT: load      = load_ready;
      default: ;
    endcase
  end

  // state and per-channel working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcwsm_pkg::ST_IDLE;
      ch_q         <= '0;
      stale_flag_q <= 1'b0;
      zero_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mcwsm_pkg::ST_IDLE:   ch_q         <= '0;
        mcwsm_pkg::ST_RD_OLD: stale_flag_q <= (hist_stale >= stale_limit_q);
        mcwsm_pkg::ST_SPAN:   zero_q       <= stale_flag_q || (span == '0);
        mcwsm_pkg::ST_EMIT: begin
          if (load_ready && !last_ch) begin
            ch_q <= ch_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // oldest timestamp arrives during the newest read
  always_ff @(posedge clk_i) begin
    if (state_q == mcwsm_pkg::ST_RD_NEW) begin
      old_q <= hist_rd_data;
    end
  end

  // result of the current channel
  always_comb begin
    res.ch   = mcwsm_pkg::CH_FIELD_W'(ch_q);
    res.q    = zero_q ? '0 : div_quot;
    res.last = last_ch;
  end

  mcwsm_history #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hist_ctrl),
    .wr_ch_i    (CW'(channel_i)),
    .wr_ts_i    (TIME_WIDTH'(timestamp_i)),
    .rd_ch_i    (ch_q),
    .rd_data_o  (hist_rd_data),
    .rd_stale_o (hist_stale)
  );

  mcwsm_serial_div #(
    .NW (NW),
    .TW (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  mcwsm_out_stage u_out (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (load),
    .res_i              (res),
    .load_ready_o       (load_ready),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .report_channel_o   (report_channel_o),
    .speed_whole_o      (speed_whole_o),
    .speed_hundredths_o (speed_hundredths_o),
    .last_o             (last_o)
  );

endmodule
